[rtl/core/cafu_pkg.sv]
// ============================================================================
// cafu_pkg
// Shared types and codes for the 8-bit CPU ALU with Z, N, H and C flags.
// ============================================================================
package cafu_pkg;

   // Operation codes carried in the mode field.
   localparam logic [4:0] MODE_ADD   = 5'd0;
   localparam logic [4:0] MODE_ADC   = 5'd1;
   localparam logic [4:0] MODE_SUB   = 5'd2;
   localparam logic [4:0] MODE_SBC   = 5'd3;
   localparam logic [4:0] MODE_AND   = 5'd4;
   localparam logic [4:0] MODE_XOR   = 5'd5;
   localparam logic [4:0] MODE_OR    = 5'd6;
   localparam logic [4:0] MODE_CP    = 5'd7;
   localparam logic [4:0] MODE_INC8  = 5'd8;
   localparam logic [4:0] MODE_DEC8  = 5'd9;
   localparam logic [4:0] MODE_RLCA  = 5'd10;
   localparam logic [4:0] MODE_RRCA  = 5'd11;
   localparam logic [4:0] MODE_RLA   = 5'd12;
   localparam logic [4:0] MODE_RRA   = 5'd13;
   localparam logic [4:0] MODE_DAA   = 5'd14;
   localparam logic [4:0] MODE_CPL   = 5'd15;
   localparam logic [4:0] MODE_SCF   = 5'd16;
   localparam logic [4:0] MODE_CCF   = 5'd17;
   localparam logic [4:0] MODE_CB    = 5'd18;
   localparam logic [4:0] MODE_ADD16 = 5'd19;
   localparam logic [4:0] MODE_SPOFF = 5'd20;
   localparam logic [4:0] MODE_INC16 = 5'd21;
   localparam logic [4:0] MODE_DEC16 = 5'd22;

   // CB-prefix groups (opcode bits 7-6).
   localparam logic [1:0] CB_GRP_SHIFT = 2'd0;
   localparam logic [1:0] CB_GRP_BIT   = 2'd1;
   localparam logic [1:0] CB_GRP_RES   = 2'd2;
   localparam logic [1:0] CB_GRP_SET   = 2'd3;

   // CB shift kinds (opcode bits 5-3 in the shift group).
   localparam logic [2:0] CB_RLC  = 3'd0;
   localparam logic [2:0] CB_RRC  = 3'd1;
   localparam logic [2:0] CB_RL   = 3'd2;
   localparam logic [2:0] CB_RR   = 3'd3;
   localparam logic [2:0] CB_SLA  = 3'd4;
   localparam logic [2:0] CB_SRA  = 3'd5;
   localparam logic [2:0] CB_SWAP = 3'd6;
   localparam logic [2:0] CB_SRL  = 3'd7;

   // Flag bit positions.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust constants.
   localparam logic [7:0] DAA_ADJ_LO = 8'h06;
   localparam logic [7:0] DAA_ADJ_HI = 8'h60;
   localparam logic [7:0] DAA_LIMIT  = 8'h99;
   localparam logic [3:0] DAA_DIGIT  = 4'd9;

   // Request and response payloads.
   typedef struct packed {
      logic [4:0]  mode;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [7:0]  cb_opcode;
      logic [3:0]  flags_in;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
      logic        write_result;
   } rsp_payload_type;

   // Result of the CB-prefix unit.
   typedef struct packed {
      logic [7:0] result;
      logic [3:0] flags;
      logic       write;
   } cb_out_type;

endpackage

[rtl/core/cafu_cb.sv]
// ============================================================================
// cafu_cb
// CB-prefix unit: rotates, shifts, swap, and bit test, reset and set.
// ============================================================================
module cafu_cb
   import cafu_pkg::*;
(
   input  logic [7:0] value,
   input  logic [7:0] cb_opcode,
   input  logic [3:0] flags_in,
   output cb_out_type cb_out
);

   logic [1:0] grp;
   logic [2:0] idx;
   logic       cin;
   logic [7:0] bit_mask;
   logic [7:0] shift_res;
   logic       shift_c;

   assign grp      = cb_opcode[7:6];
   assign idx      = cb_opcode[5:3];
   assign cin      = flags_in[FLAG_C];
   assign bit_mask = 8'd1 << idx;

   // Shift and rotate group.
   always_comb begin
      case (idx)
         CB_RLC: begin
            shift_c   = value[7];
            shift_res = {value[6:0], value[7]};
         end
         CB_RRC: begin
            shift_c   = value[0];
            shift_res = {value[0], value[7:1]};
         end
         CB_RL: begin
            shift_c   = value[7];
            shift_res = {value[6:0], cin};
         end
         CB_RR: begin
            shift_c   = value[0];
            shift_res = {cin, value[7:1]};
         end
         CB_SLA: begin
            shift_c   = value[7];
            shift_res = {value[6:0], 1'b0};
         end
         CB_SRA: begin
            shift_c   = value[0];
            shift_res = {value[7], value[7:1]};
         end
         CB_SWAP: begin
            shift_c   = 1'b0;
            shift_res = {value[3:0], value[7:4]};
         end
         default: begin
            shift_c   = value[0];
            shift_res = {1'b0, value[7:1]};
         end
      endcase
   end

   // Group select.
   always_comb begin
      unique case (grp)
         CB_GRP_BIT: begin
            cb_out.result = value;
            cb_out.flags  = {~value[idx], 1'b0, 1'b1, cin};
            cb_out.write  = 1'b0;
         end
         CB_GRP_RES: begin
            cb_out.result = value & ~bit_mask;
            cb_out.flags  = flags_in;
            cb_out.write  = 1'b1;
         end
         CB_GRP_SET: begin
            cb_out.result = value | bit_mask;
            cb_out.flags  = flags_in;
            cb_out.write  = 1'b1;
         end
         default: begin
            cb_out.result = shift_res;
            cb_out.flags  = {(shift_res == 8'd0), 1'b0, 1'b0, shift_c};
            cb_out.write  = 1'b1;
         end
      endcase
   end

endmodule

[rtl/core/cafu_exec.sv]
// ============================================================================
// cafu_exec
// Single-pass ALU datapath: 8-bit and 16-bit arithmetic, logic and flags.
// ============================================================================
module cafu_exec
   import cafu_pkg::*;
(
   input  req_payload_type req,
   output rsp_payload_type rsp
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic        fz;
   logic        fn;
   logic        fh;
   logic        add_cin;
   logic        sub_cin;
   logic [8:0]  add_sum;
   logic [4:0]  add_half;
   logic [8:0]  sub_diff;
   logic [4:0]  sub_half;
   logic [7:0]  inc_res;
   logic [7:0]  dec_res;
   logic        daa_lo;
   logic        daa_hi;
   logic [7:0]  daa_adj;
   logic [7:0]  daa_res;
   logic [16:0] add16_sum;
   logic [12:0] add16_half;
   logic [15:0] sp_res;
   logic [8:0]  sp_lo;
   logic [4:0]  sp_half;
   cb_out_type  cb_out;

   assign a   = req.operand_a[7:0];
   assign b   = req.operand_b[7:0];
   assign cin = req.flags_in[FLAG_C];
   assign fz  = req.flags_in[FLAG_Z];
   assign fn  = req.flags_in[FLAG_N];
   assign fh  = req.flags_in[FLAG_H];

   // 8-bit adder and subtractor with carry-in from C for adc and sbc.
   assign add_cin  = (req.mode == MODE_ADC) & cin;
   assign sub_cin  = (req.mode == MODE_SBC) & cin;
   assign add_sum  = {1'b0, a} + {1'b0, b} + {8'd0, add_cin};
   assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cin};
   assign sub_diff = {1'b0, a} - {1'b0, b} - {8'd0, sub_cin};
   assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_cin};
   assign inc_res  = a + 8'd1;
   assign dec_res  = a - 8'd1;

   // Decimal adjust after an addition or a subtraction.
   assign daa_lo  = fh | (~fn & (a[3:0] > DAA_DIGIT));
   assign daa_hi  = cin | (~fn & (a > DAA_LIMIT));
   assign daa_adj = (daa_lo ? DAA_ADJ_LO : 8'd0) | (daa_hi ? DAA_ADJ_HI : 8'd0);
   assign daa_res = fn ? (a - daa_adj) : (a + daa_adj);

   // 16-bit add to HL and SP plus signed offset.
   assign add16_sum  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign add16_half = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
   assign sp_res     = req.operand_a + {{8{b[7]}}, b};
   assign sp_lo      = {1'b0, req.operand_a[7:0]} + {1'b0, b};
   assign sp_half    = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};

   cafu_cb u_cb (
      .value     (a),
      .cb_opcode (req.cb_opcode),
      .flags_in  (req.flags_in),
      .cb_out    (cb_out)
   );

   // Operation select.
   always_comb begin
      rsp.result       = {8'd0, a};
      rsp.flags_out    = req.flags_in;
      rsp.write_result = 1'b1;
      unique case (req.mode) inside
         MODE_ADD, MODE_ADC: begin
            rsp.result    = {8'd0, add_sum[7:0]};
            rsp.flags_out = {(add_sum[7:0] == 8'd0), 1'b0, add_half[4], add_sum[8]};
         end
         MODE_SUB, MODE_SBC: begin
            rsp.result    = {8'd0, sub_diff[7:0]};
            rsp.flags_out = {(sub_diff[7:0] == 8'd0), 1'b1, sub_half[4], sub_diff[8]};
         end
         MODE_CP: begin
            rsp.flags_out    = {(sub_diff[7:0] == 8'd0), 1'b1, sub_half[4], sub_diff[8]};
            rsp.write_result = 1'b0;
         end
         MODE_AND: begin
            rsp.result    = {8'd0, a & b};
            rsp.flags_out = {((a & b) == 8'd0), 1'b0, 1'b1, 1'b0};
         end
         MODE_XOR: begin
            rsp.result    = {8'd0, a ^ b};
            rsp.flags_out = {((a ^ b) == 8'd0), 3'b000};
         end
         MODE_OR: begin
            rsp.result    = {8'd0, a | b};
            rsp.flags_out = {((a | b) == 8'd0), 3'b000};
         end
         MODE_INC8: begin
            rsp.result    = {8'd0, inc_res};
            rsp.flags_out = {(inc_res == 8'd0), 1'b0, (inc_res[3:0] == 4'h0), cin};
         end
         MODE_DEC8: begin
            rsp.result    = {8'd0, dec_res};
            rsp.flags_out = {(dec_res == 8'd0), 1'b1, (dec_res[3:0] == 4'hF), cin};
         end
         MODE_RLCA: begin
            rsp.result    = {8'd0, a[6:0], a[7]};
            rsp.flags_out = {3'b000, a[7]};
         end
         MODE_RRCA: begin
            rsp.result    = {8'd0, a[0], a[7:1]};
            rsp.flags_out = {3'b000, a[0]};
         end
         MODE_RLA: begin
            rsp.result    = {8'd0, a[6:0], cin};
            rsp.flags_out = {3'b000, a[7]};
         end
         MODE_RRA: begin
            rsp.result    = {8'd0, cin, a[7:1]};
            rsp.flags_out = {3'b000, a[0]};
         end
         MODE_DAA: begin
            rsp.result    = {8'd0, daa_res};
            rsp.flags_out = {(daa_res == 8'd0), fn, 1'b0, daa_hi};
         end
         MODE_CPL: begin
            rsp.result    = {8'd0, ~a};
            rsp.flags_out = {fz, 1'b1, 1'b1, cin};
         end
         MODE_SCF: begin
            rsp.flags_out    = {fz, 1'b0, 1'b0, 1'b1};
            rsp.write_result = 1'b0;
         end
         MODE_CCF: begin
            rsp.flags_out    = {fz, 1'b0, 1'b0, ~cin};
            rsp.write_result = 1'b0;
         end
         MODE_CB: begin
            rsp.result       = {8'd0, cb_out.result};
            rsp.flags_out    = cb_out.flags;
            rsp.write_result = cb_out.write;
         end
         MODE_ADD16: begin
            rsp.result    = add16_sum[15:0];
            rsp.flags_out = {fz, 1'b0, add16_half[12], add16_sum[16]};
         end
         MODE_SPOFF: begin
            rsp.result    = sp_res;
            rsp.flags_out = {1'b0, 1'b0, sp_half[4], sp_lo[8]};
         end
         MODE_INC16: begin
            rsp.result = req.operand_a + 16'd1;
         end
         MODE_DEC16: begin
            rsp.result = req.operand_a - 16'd1;
         end
         default: begin
            // Unused codes pass the first operand through untouched.
            rsp.result       = req.operand_a;
            rsp.write_result = 1'b0;
         end
      endcase
   end

endmodule

[rtl/core/cpu_alu_with_flags_unit.sv]
// ============================================================================
// cpu_alu_with_flags_unit
// 8-bit CPU ALU with Z, N, H and C flags, registered in and out.
// ============================================================================
// Usage:
//   A request carries an operation code, two 16-bit operands, a CB-prefix
//   byte and the current flags. It is taken on a rising edge with req_valid
//   high and req_stall low. Each request produces exactly one response with
//   the result, the new flags and the write-back bit, offered on rsp_valid
//   and taken on an edge with rsp_stall low.
//   The accepting edge loads the input register, and the ALU output is loaded
//   into the result register once that register is empty or taken, which
//   raises rsp_valid; a full, stalled result register holds the request back.
//   Throughput is one request per cycle while the receiver does not stall;
//   the whole operation is a single pass of logic between the two registers.
//   While the receiver stalls, the response holds and one more request can
//   wait in the input register; only then does req_stall rise.
//   Reset clears both valid bits; no request is in flight afterwards.
// ============================================================================
module cpu_alu_with_flags_unit
   import cafu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_payload_type s1_data_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type alu_out;
   logic            out_ready;
   logic            s1_load;

   // Handshake: the result register frees up when empty or taken.
   assign out_ready   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall   = s1_valid_ff & ~out_ready;
   assign s1_load     = req_valid & ~req_stall;
   assign s1_valid_in = s1_load | (s1_valid_ff & ~out_ready);
   assign rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_load) begin
         s1_data_ff <= req_data;
      end
   end

   cafu_exec u_exec (
      .req (s1_data_ff),
      .rsp (alu_out)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_ready && s1_valid_ff) begin
         rsp_data_ff <= alu_out;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted request always lands in the input register.
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted request did not reach the input register");

   // A request waiting behind a free result register moves on next cycle.
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_stall) |=> rsp_valid)
      else $error("pending request did not reach the result register");

   // Backpressure appears only with both stages full and the output stalled.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid && rsp_stall))
      else $error("request stall without a full pipeline");

endmodule
